FILE: rtl/spt_pkg.sv
package spt_pkg;

    typedef logic signed [32:0] t_mul_op;
    typedef logic signed [65:0] t_mul_prod;

    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_SOGI_GAIN     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SOGI_FREQ     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_PERIOD = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PI_KP         = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PI_KI         = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_LIMIT    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_NOMINAL_FREQ  = 3'd6;

    localparam logic [15:0] RST_SOGI_GAIN     = 16'd23167;
    localparam logic [25:0] RST_SOGI_FREQ     = 26'd20588741;
    localparam logic [31:0] RST_SAMPLE_PERIOD = 32'd214748;
    localparam logic [23:0] RST_PI_KP         = 24'd37421;
    localparam logic [23:0] RST_PI_KI         = 24'd3326997;
    localparam logic [23:0] RST_FREQ_LIMIT    = 24'd4117687;
    localparam logic [25:0] RST_NOMINAL_FREQ  = 26'd20588741;

    localparam int          SAMPLE_SHIFT      = 8;
    localparam longint      HALF_PI_Q30       = 64'd1686629713;
    localparam int          TWO_PI_Q28        = 32'sd1686629713;
    localparam logic [31:0] EIGHT_OVER_PI_Q30 = 32'd2734261102;
    localparam logic [31:0] QUARTER_TURN      = 32'h4000_0000;
    localparam logic [15:0] QUARTER_VALUE     = 16'd32768;

endpackage

FILE: rtl/spt_mult.sv
module spt_mult (
    input  logic               i_clk,
    input  spt_pkg::t_mul_op   i_a,
    input  spt_pkg::t_mul_op   i_b,
    output spt_pkg::t_mul_prod o_prod
);

    spt_pkg::t_mul_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/spt_sine_rom.sv
module spt_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic        [31:0] i_phase,
    output logic signed [16:0] o_sine
);

    localparam int TABLE_SIZE = 1 << TABLE_BITS;

    function automatic logic [15:0] rom_entry(input int unsigned idx);
        logic        [63:0] x;
        logic        [63:0] x2;
        logic        [63:0] term;
        logic signed [63:0] sum;
        x    = (64'(spt_pkg::HALF_PI_Q30) * 64'(idx)) >> TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 6; k++) begin
            term = (term * x2) >> 30;
            case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if ((k & 1) != 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd32768) begin
            sum = 64'sd32768;
        end
        return 16'(sum);
    endfunction

    logic [15:0] sine_rom [TABLE_SIZE];

    for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
        localparam logic [15:0] ENTRY = rom_entry(gi);
        assign sine_rom[gi] = ENTRY;
    end

    logic [TABLE_BITS-1:0] idx;
    logic [TABLE_BITS-1:0] addr;
    logic                  full;
    logic [15:0]           r_mag;
    logic                  r_neg;

    // The second and fourth quadrants read the table mirrored; the mirror of index zero is
    // the quarter point itself, which lies just past the end of the table.
    assign idx  = i_phase[29 -: TABLE_BITS];
    assign addr = i_phase[30] ? TABLE_BITS'(~idx + 1'b1) : idx;
    assign full = i_phase[30] && (idx == '0);

    always_ff @(posedge i_clk) begin
        r_mag <= full ? spt_pkg::QUARTER_VALUE : sine_rom[addr];
        r_neg <= i_phase[31];
    end

    assign o_sine = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});

endmodule

FILE: rtl/sogi_pll_phase_tracker.sv
// Single-phase grid PLL built around a second-order generalised integrator.
// Each request on the slave stream carries one grid voltage sample (Q7.8 volts). For every
// request the block returns one result on the master stream: the new phase angle in
// tdata[31:0] (Q3.28 rad, within plus or minus two pi) and the clamped frequency offset in
// tdata[56:32] (Q8.16 rad/s).
// The work runs through a single registered 33 by 33 bit multiplier under a sequencer, one
// product per step, and the slave side is ready again only once the result has been handed
// to the output register, so a new request is taken only after the last one is finished.
// The gains and frequencies sit on a plain write port and may be changed only while the
// block is idle; writes to an unused index are ignored.
// A synchronous reset restores the register defaults, clears the integrators, the frequency
// accumulator, the stored error and the angle, and empties the output register. The sine
// table is a constant ROM and needs no fill after reset.
// When the receiver stalls, the result stays in the output register; a finished request
// waits in its last step until that register is free, and no new sample is taken meanwhile.
module sogi_pll_phase_tracker #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [spt_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [31:0]                         i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: grid_sample.
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: tracked_angle (32 bits), freq_offset (25 bits).
    output logic [63:0]                         m_axis_tdata
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_TW    = 5'd1;
    localparam logic [4:0] ST_GAIN  = 5'd2;
    localparam logic [4:0] ST_TERM  = 5'd3;
    localparam logic [4:0] ST_PHASE = 5'd4;
    localparam logic [4:0] ST_ALPHA = 5'd5;
    localparam logic [4:0] ST_BTW   = 5'd6;
    localparam logic [4:0] ST_BETA  = 5'd7;
    localparam logic [4:0] ST_BC    = 5'd8;
    localparam logic [4:0] ST_AS    = 5'd9;
    localparam logic [4:0] ST_ERR   = 5'd10;
    localparam logic [4:0] ST_EDIFF = 5'd11;
    localparam logic [4:0] ST_KP    = 5'd12;
    localparam logic [4:0] ST_KI    = 5'd13;
    localparam logic [4:0] ST_CLAMP = 5'd14;
    localparam logic [4:0] ST_OMEGA = 5'd15;
    localparam logic [4:0] ST_STEP  = 5'd16;
    localparam logic [4:0] ST_ANGLE = 5'd17;
    localparam logic [4:0] ST_WRAP  = 5'd18;
    localparam logic [4:0] ST_DONE  = 5'd19;

    localparam logic signed [52:0] SAT_MAX = 53'sd2147483647;
    localparam logic signed [52:0] SAT_MIN = -53'sd2147483648;
    localparam logic signed [40:0] TWO_PI  = 41'(spt_pkg::TWO_PI_Q28);
    localparam logic signed [31:0] TWO_PI_32 = 32'(spt_pkg::TWO_PI_Q28);

    function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
        if (v > SAT_MAX) begin
            return 32'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            return 32'(SAT_MIN);
        end
        return 32'(v);
    endfunction

    logic [4:0] r_state;

    logic [15:0] r_sogi_gain;
    logic [25:0] r_sogi_freq;
    logic [31:0] r_sample_period;
    logic [23:0] r_pi_kp;
    logic [23:0] r_pi_ki;
    logic [23:0] r_freq_limit;
    logic [25:0] r_nominal_freq;

    logic signed [31:0] r_alpha;
    logic signed [31:0] r_beta;
    logic signed [24:0] r_facc;
    logic signed [31:0] r_prev;
    logic signed [31:0] r_last;

    logic signed [32:0] r_x_diff;
    logic        [31:0] r_tw;
    logic signed [31:0] r_t;
    logic        [31:0] r_ph;
    logic signed [16:0] r_sin;
    logic signed [16:0] r_cos;
    logic signed [49:0] r_bc;
    logic signed [31:0] r_err;
    logic signed [32:0] r_ediff;
    logic signed [41:0] r_acc;
    logic signed [27:0] r_omega;
    logic signed [40:0] r_th;
    logic signed [40:0] r_wrap;
    logic               r_out_valid;
    logic signed [31:0] r_out_phase;
    logic signed [24:0] r_out_offset;

    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic signed [31:0] n_x;
    logic signed [32:0] n_x_diff;
    logic        [31:0] n_tw;
    logic signed [31:0] n_t;
    logic signed [31:0] n_alpha;
    logic signed [31:0] n_beta;
    logic signed [50:0] n_proj;
    logic signed [31:0] n_err;
    logic signed [32:0] n_ediff;
    logic signed [41:0] n_acc;
    logic signed [42:0] n_sum;
    logic signed [42:0] n_lim;
    logic signed [24:0] n_facc;
    logic signed [27:0] n_omega;
    logic signed [40:0] n_th;
    logic signed [40:0] n_wrap;
    logic signed [31:0] n_last;
    logic               out_load;

    spt_pkg::t_mul_op   mul_a;
    spt_pkg::t_mul_op   mul_b;
    spt_pkg::t_mul_prod mul_prod;
    logic        [31:0] rom_phase;
    logic signed [16:0] rom_sine;

    spt_mult u_mult (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    assign rom_phase = (r_state == ST_BTW) ? r_ph + spt_pkg::QUARTER_TURN : r_ph;

    spt_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk   (i_clk),
        .i_phase (rom_phase),
        .o_sine  (rom_sine)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_TW: begin
                mul_a = $signed({1'b0, r_sample_period});
                mul_b = $signed({7'b0, r_sogi_freq});
            end
            ST_GAIN: begin
                mul_a = r_x_diff;
                mul_b = $signed({17'b0, r_sogi_gain});
            end
            ST_TERM: begin
                mul_a = 33'(r_last);
                mul_b = $signed({1'b0, spt_pkg::EIGHT_OVER_PI_Q30});
            end
            ST_PHASE: begin
                mul_a = 33'(r_t);
                mul_b = $signed({1'b0, r_tw});
            end
            ST_BTW: begin
                mul_a = 33'(r_alpha);
                mul_b = $signed({1'b0, r_tw});
            end
            ST_BC: begin
                mul_a = 33'(r_beta);
                mul_b = 33'(r_cos);
            end
            ST_AS: begin
                mul_a = 33'(r_alpha);
                mul_b = 33'(r_sin);
            end
            ST_KP: begin
                mul_a = r_ediff;
                mul_b = $signed({9'b0, r_pi_kp});
            end
            ST_KI: begin
                mul_a = 33'(r_err);
                mul_b = $signed({9'b0, r_pi_ki});
            end
            ST_STEP: begin
                mul_a = 33'(r_omega);
                mul_b = $signed({1'b0, r_sample_period});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign smp      = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign n_x      = 32'(smp) <<< spt_pkg::SAMPLE_SHIFT;
    assign n_x_diff = 33'(n_x) - 33'(r_alpha);
    assign n_tw     = (mul_prod[65:48] != '0) ? 32'hFFFF_FFFF : mul_prod[47:16];
    assign n_t      = sat32(53'($signed(mul_prod[65:14])) - 53'(r_beta));
    assign n_alpha  = sat32(53'($signed(mul_prod[65:32])) + 53'(r_alpha));
    assign n_beta   = sat32(53'($signed(mul_prod[65:32])) + 53'(r_beta));
    assign n_proj   = 51'(r_bc) - 51'($signed(mul_prod[49:0]));
    assign n_err    = sat32(53'($signed(n_proj[50:15])));
    assign n_ediff  = 33'(r_err) - 33'(r_prev);
    assign n_acc    = 42'(r_facc) + 42'($signed(mul_prod[56:16]));
    assign n_sum    = 43'(r_acc) + 43'($signed(mul_prod[55:16]));
    assign n_lim    = $signed({19'b0, r_freq_limit});
    assign n_omega  = $signed({2'b0, r_nominal_freq}) + 28'(r_facc);
    assign n_th     = 41'(r_last) + $signed(mul_prod[60:20]);
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    always_comb begin
        if (n_sum > n_lim) begin
            n_facc = 25'(n_lim);
        end else if (n_sum < -n_lim) begin
            n_facc = 25'(-n_lim);
        end else begin
            n_facc = 25'(n_sum);
        end
    end

    always_comb begin
        if (r_th > TWO_PI) begin
            n_wrap = r_th - TWO_PI;
        end else if (r_th < -TWO_PI) begin
            n_wrap = r_th + TWO_PI;
        end else begin
            n_wrap = r_th;
        end
    end

    always_comb begin
        if (r_wrap > TWO_PI) begin
            n_last = TWO_PI_32;
        end else if (r_wrap < -TWO_PI) begin
            n_last = -TWO_PI_32;
        end else begin
            n_last = 32'(r_wrap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_out_valid     <= 1'b0;
            r_sogi_gain     <= spt_pkg::RST_SOGI_GAIN;
            r_sogi_freq     <= spt_pkg::RST_SOGI_FREQ;
            r_sample_period <= spt_pkg::RST_SAMPLE_PERIOD;
            r_pi_kp         <= spt_pkg::RST_PI_KP;
            r_pi_ki         <= spt_pkg::RST_PI_KI;
            r_freq_limit    <= spt_pkg::RST_FREQ_LIMIT;
            r_nominal_freq  <= spt_pkg::RST_NOMINAL_FREQ;
            r_alpha         <= '0;
            r_beta          <= '0;
            r_facc          <= '0;
            r_prev          <= '0;
            r_last          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    spt_pkg::CFG_SOGI_GAIN:     r_sogi_gain     <= i_cfg_wdata[15:0];
                    spt_pkg::CFG_SOGI_FREQ:     r_sogi_freq     <= i_cfg_wdata[25:0];
                    spt_pkg::CFG_SAMPLE_PERIOD: r_sample_period <= i_cfg_wdata;
                    spt_pkg::CFG_PI_KP:         r_pi_kp         <= i_cfg_wdata[23:0];
                    spt_pkg::CFG_PI_KI:         r_pi_ki         <= i_cfg_wdata[23:0];
                    spt_pkg::CFG_FREQ_LIMIT:    r_freq_limit    <= i_cfg_wdata[23:0];
                    spt_pkg::CFG_NOMINAL_FREQ:  r_nominal_freq  <= i_cfg_wdata[25:0];
                    default: begin
                    end
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= ST_TW;
                    end
                end
                ST_TW:    r_state <= ST_GAIN;
                ST_GAIN:  r_state <= ST_TERM;
                ST_TERM:  r_state <= ST_PHASE;
                ST_PHASE: r_state <= ST_ALPHA;
                ST_ALPHA: begin
                    r_alpha <= n_alpha;
                    r_state <= ST_BTW;
                end
                ST_BTW:   r_state <= ST_BETA;
                ST_BETA: begin
                    r_beta  <= n_beta;
                    r_state <= ST_BC;
                end
                ST_BC:    r_state <= ST_AS;
                ST_AS:    r_state <= ST_ERR;
                ST_ERR:   r_state <= ST_EDIFF;
                ST_EDIFF: r_state <= ST_KP;
                ST_KP:    r_state <= ST_KI;
                ST_KI:    r_state <= ST_CLAMP;
                ST_CLAMP: begin
                    r_facc  <= n_facc;
                    r_prev  <= r_err;
                    r_state <= ST_OMEGA;
                end
                ST_OMEGA: r_state <= ST_STEP;
                ST_STEP:  r_state <= ST_ANGLE;
                ST_ANGLE: r_state <= ST_WRAP;
                ST_WRAP:  r_state <= ST_DONE;
                ST_DONE: begin
                    if (out_load) begin
                        r_last  <= n_last;
                        r_state <= ST_IDLE;
                    end
                end
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_x_diff <= n_x_diff;
        end
        if (r_state == ST_GAIN) begin
            r_tw <= n_tw;
        end
        if (r_state == ST_TERM) begin
            r_t <= n_t;
        end
        if (r_state == ST_PHASE) begin
            r_ph <= mul_prod[61:30];
        end
        if (r_state == ST_BTW) begin
            r_sin <= rom_sine;
        end
        if (r_state == ST_BETA) begin
            r_cos <= rom_sine;
        end
        if (r_state == ST_AS) begin
            r_bc <= mul_prod[49:0];
        end
        if (r_state == ST_ERR) begin
            r_err <= n_err;
        end
        if (r_state == ST_EDIFF) begin
            r_ediff <= n_ediff;
        end
        if (r_state == ST_KI) begin
            r_acc <= n_acc;
        end
        if (r_state == ST_OMEGA) begin
            r_omega <= n_omega;
        end
        if (r_state == ST_ANGLE) begin
            r_th <= n_th;
        end
        if (r_state == ST_WRAP) begin
            r_wrap <= n_wrap;
        end
        if (out_load) begin
            r_out_phase  <= n_last;
            r_out_offset <= r_facc;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_offset, r_out_phase};

    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("A second sample was taken while a request was still in progress.");

    a_offset_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_offset <= $signed({1'b0, r_freq_limit}))
                       && (r_out_offset >= -$signed({1'b0, r_freq_limit})))
        else $error("The frequency offset of a result lies outside the configured limit.");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_phase <= TWO_PI_32) && (r_out_phase >= -TWO_PI_32))
        else $error("The phase angle of a result lies outside plus or minus two pi.");

endmodule

FILE: bench/tb_sogi_pll_phase_tracker.sv
module tb_sogi_pll_phase_tracker;

    localparam int     ROM_BITS       = 10;
    localparam int     ROM_SIZE       = 1 << ROM_BITS;
    localparam int     SAMPLE_BITS    = 16;
    localparam longint QUARTER_ARC_Q30 = 64'sd1686629713;
    localparam longint ANGLE_WRAP     = 64'sd1686629713;
    localparam longint TURN_SCALE_Q30 = 64'sd2734261102;
    localparam longint PEAK_SINE      = 64'sd32768;
    localparam longint STEP_GAIN_MAX  = 64'sh0000_0000_FFFF_FFFF;
    localparam longint INT32_TOP      = 64'sh0000_0000_7FFF_FFFF;
    localparam longint INT32_BOTTOM   = -64'sh0000_0000_8000_0000;
    localparam logic [spt_pkg::CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;
    localparam int     LATENCY_CYCLES = 24;
    localparam int     SENDER         = 0;
    localparam int     RECEIVER       = 1;
    localparam real    PI             = 3.14159265358979;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [spt_pkg::CFG_ADDR_W-1:0]    i_cfg_addr = '0;
    logic [31:0]                       i_cfg_wdata = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    // Fields from bit 0: grid_sample.
    logic [15:0]                       s_axis_tdata = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // Fields from bit 0: tracked_angle (32 bits), freq_offset (25 bits).
    logic [63:0]                       m_axis_tdata;

    typedef struct packed {
        logic [31:0] tracked_angle;
        logic [24:0] freq_offset;
    } t_pll_result;

    t_pll_result pending_results[$];

    logic [15:0] k_gain;
    logic [25:0] sogi_w;
    logic [31:0] ts;
    logic [23:0] kp;
    logic [23:0] ki;
    logic [23:0] f_limit;
    logic [25:0] w_nominal;

    int alpha_int;
    int beta_int;
    int freq_acc;
    int last_err;
    int theta;
    int sine_rom[ROM_SIZE];

    int fail_count = 0;
    int run_left[2] = '{0, 0};
    bit run_calm[2] = '{1'b0, 1'b0};

    sogi_pll_phase_tracker #(
        .SINE_TABLE_BITS(ROM_BITS),
        .SAMPLE_WIDTH   (SAMPLE_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_wait(int side);
        if (run_left[side] == 0) begin
            run_left[side] = $urandom_range(8, 48);
            run_calm[side] = ($urandom_range(0, 3) == 0);
        end
        run_left[side]--;
        return run_calm[side] ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic int clip32(longint v);
        if (v > INT32_TOP) return int'(INT32_TOP);
        if (v < INT32_BOTTOM) return int'(INT32_BOTTOM);
        return int'(v);
    endfunction

    function automatic int rom_value(int i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        x = (QUARTER_ARC_Q30 * longint'(i)) >> ROM_BITS;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int k = 1; k <= 6; k++) begin
            term = (term * x2) >> 30;
            term = term / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        sum = (sum + 16384) >>> 15;
        if (sum > PEAK_SINE) sum = PEAK_SINE;
        return int'(sum);
    endfunction

    function automatic longint rom_read(int j);
        if (j >= ROM_SIZE) return PEAK_SINE;
        return longint'(sine_rom[j]);
    endfunction

    function automatic longint sine_of_turn(logic [31:0] ph);
        logic [ROM_BITS-1:0] idx;
        longint mag;
        idx = ph[29 -: ROM_BITS];
        if (ph[30]) mag = rom_read(ROM_SIZE - int'(idx));
        else mag = rom_read(int'(idx));
        return ph[31] ? -mag : mag;
    endfunction

    function automatic t_pll_result track_sample(logic [15:0] v);
        longint x;
        longint t;
        longint tw;
        longint s;
        longint c;
        longint e;
        longint acc;
        longint lim;
        longint omega;
        longint th;
        longint turn;
        t_pll_result r;
        x = longint'($signed(v)) * 256;
        tw = (longint'(ts) * longint'(sogi_w)) >>> 16;
        if (tw > STEP_GAIN_MAX) tw = STEP_GAIN_MAX;

        t = (((x - alpha_int) * longint'(k_gain)) >>> 14) - beta_int;
        alpha_int = clip32(alpha_int + ((longint'(clip32(t)) * tw) >>> 32));
        beta_int = clip32(beta_int + ((longint'(alpha_int) * tw) >>> 32));

        turn = (longint'(theta) * TURN_SCALE_Q30) >>> 30;
        s = sine_of_turn(turn[31:0]);
        c = sine_of_turn(turn[31:0] + 32'h4000_0000);
        e = clip32((longint'(beta_int) * c - longint'(alpha_int) * s) >>> 15);

        acc = longint'(freq_acc) + (((e - last_err) * longint'(kp)) >>> 16)
            + ((e * longint'(ki)) >>> 16);
        last_err = int'(e);
        lim = longint'(f_limit);
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        freq_acc = int'(acc);

        omega = longint'(w_nominal) + acc;
        th = longint'(theta) + ((omega * longint'(ts)) >>> 20);
        if (th > ANGLE_WRAP) th -= ANGLE_WRAP;
        if (th < -ANGLE_WRAP) th += ANGLE_WRAP;
        if (th > ANGLE_WRAP) th = ANGLE_WRAP;
        if (th < -ANGLE_WRAP) th = -ANGLE_WRAP;
        theta = int'(th);

        r.tracked_angle = th[31:0];
        r.freq_offset = acc[24:0];
        return r;
    endfunction

    function automatic void store_setting(logic [spt_pkg::CFG_ADDR_W-1:0] a, logic [31:0] d);
        case (a)
            spt_pkg::CFG_SOGI_GAIN:     k_gain = d[15:0];
            spt_pkg::CFG_SOGI_FREQ:     sogi_w = d[25:0];
            spt_pkg::CFG_SAMPLE_PERIOD: ts = d;
            spt_pkg::CFG_PI_KP:         kp = d[23:0];
            spt_pkg::CFG_PI_KI:         ki = d[23:0];
            spt_pkg::CFG_FREQ_LIMIT:    f_limit = d[23:0];
            spt_pkg::CFG_NOMINAL_FREQ:  w_nominal = d[25:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] pick_setting(logic [31:0] top, logic [31:0] usual);
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return top;
            2: return $urandom() & top;
            default: return $urandom_range(usual / 2, usual + usual / 2) & top;
        endcase
    endfunction

    task automatic reset_tracker_model();
        k_gain = spt_pkg::RST_SOGI_GAIN;
        sogi_w = spt_pkg::RST_SOGI_FREQ;
        ts = spt_pkg::RST_SAMPLE_PERIOD;
        kp = spt_pkg::RST_PI_KP;
        ki = spt_pkg::RST_PI_KI;
        f_limit = spt_pkg::RST_FREQ_LIMIT;
        w_nominal = spt_pkg::RST_NOMINAL_FREQ;
        alpha_int = 0;
        beta_int = 0;
        freq_acc = 0;
        last_err = 0;
        theta = 0;
        for (int i = 0; i < ROM_SIZE; i++) sine_rom[i] = rom_value(i);
    endtask

    task automatic send_sample(logic [15:0] v);
        int gap;
        gap = pick_wait(SENDER);
        if (gap > 0) begin
            @(negedge i_clk) s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(track_sample(v));
    endtask

    task automatic settle();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (LATENCY_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [spt_pkg::CFG_ADDR_W-1:0] a, logic [31:0] d);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= a;
        i_cfg_wdata <= d;
        store_setting(a, d);
    endtask

    task automatic write_all(logic [15:0] gain, logic [25:0] sfreq, logic [31:0] period,
                             logic [23:0] p_gain, logic [23:0] i_gain, logic [23:0] limit,
                             logic [25:0] nominal);
        write_reg(spt_pkg::CFG_SOGI_GAIN, 32'(gain));
        write_reg(spt_pkg::CFG_SOGI_FREQ, 32'(sfreq));
        write_reg(spt_pkg::CFG_SAMPLE_PERIOD, period);
        write_reg(spt_pkg::CFG_PI_KP, 32'(p_gain));
        write_reg(spt_pkg::CFG_PI_KI, 32'(i_gain));
        write_reg(spt_pkg::CFG_FREQ_LIMIT, 32'(limit));
        write_reg(spt_pkg::CFG_NOMINAL_FREQ, 32'(nominal));
        write_reg(CFG_UNUSED, $urandom());
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    task automatic write_defaults();
        write_all(spt_pkg::RST_SOGI_GAIN, spt_pkg::RST_SOGI_FREQ, spt_pkg::RST_SAMPLE_PERIOD,
                  spt_pkg::RST_PI_KP, spt_pkg::RST_PI_KI, spt_pkg::RST_FREQ_LIMIT,
                  spt_pkg::RST_NOMINAL_FREQ);
    endtask

    // A noisy sinusoid with occasional phase jumps and stray random codes over the full range.
    task automatic run_grid_wave(int count, real hz);
        real amp;
        real phi;
        real v;
        int jitter;
        int code;
        amp = $urandom_range(20, 120) * 256.0;
        phi = $urandom_range(0, 6283) / 1000.0;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) == 0) phi = phi + $urandom_range(0, 6283) / 1000.0;
            jitter = $urandom_range(0, 64);
            jitter -= 32;
            v = amp * $sin(2.0 * PI * hz * n * 0.00005 + phi) + jitter;
            if (v > 32767.0) v = 32767.0;
            if (v < -32768.0) v = -32768.0;
            code = $rtoi(v);
            if ($urandom_range(0, 199) == 0) code = $urandom_range(0, 65535);
            send_sample(code[15:0]);
        end
    endtask

    task automatic run_noise(int count);
        for (int n = 0; n < count; n++) send_sample(16'($urandom_range(0, 65535)));
    endtask

    task automatic test_sample_extremes();
        logic [15:0] corner[8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF,
                                   16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
        settle();
        foreach (corner[i]) send_sample(corner[i]);
    endtask

    // Saturated step gain, integrators, error and angle all at once.
    task automatic test_saturating_settings();
        settle();
        write_all(16'hFFFF, 26'h3FF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                  24'hFF_FFFF, 26'h3FF_FFFF);
        for (int n = 0; n < 6; n++) send_sample(n % 2 == 0 ? 16'h7FFF : 16'h8000);
    endtask

    task automatic test_zero_settings();
        settle();
        write_all('0, '0, '0, '0, '0, '0, '0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h1234);
        send_sample(16'h0000);
    endtask

    task automatic test_grid_lock();
        settle();
        write_defaults();
        run_grid_wave(450, 50.0);
    endtask

    task automatic test_off_nominal_grid();
        real hz;
        logic [25:0] w;
        for (int p = 0; p < 2; p++) begin
            hz = $urandom_range(4500, 5500) / 100.0;
            w = 26'($rtoi(2.0 * PI * hz * 65536.0));
            settle();
            write_all(spt_pkg::RST_SOGI_GAIN, w, spt_pkg::RST_SAMPLE_PERIOD, spt_pkg::RST_PI_KP,
                      spt_pkg::RST_PI_KI, spt_pkg::RST_FREQ_LIMIT, w);
            run_grid_wave(225, hz);
        end
    endtask

    // With no nominal frequency the angle follows the sign of the offset, backwards too.
    task automatic test_negative_frequency();
        settle();
        write_all(spt_pkg::RST_SOGI_GAIN, spt_pkg::RST_SOGI_FREQ, spt_pkg::RST_SAMPLE_PERIOD,
                  spt_pkg::RST_PI_KP, 24'hFF_FFFF, 24'hFF_FFFF, '0);
        run_noise(100);
        run_grid_wave(100, 50.0);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 5; p++) begin
            settle();
            write_all(pick_setting(32'h0000_FFFF, 32'(spt_pkg::RST_SOGI_GAIN)),
                      pick_setting(32'h03FF_FFFF, 32'(spt_pkg::RST_SOGI_FREQ)),
                      pick_setting(32'hFFFF_FFFF, spt_pkg::RST_SAMPLE_PERIOD),
                      pick_setting(32'h00FF_FFFF, 32'(spt_pkg::RST_PI_KP)),
                      pick_setting(32'h00FF_FFFF, 32'(spt_pkg::RST_PI_KI)),
                      pick_setting(32'h00FF_FFFF, 32'(spt_pkg::RST_FREQ_LIMIT)),
                      pick_setting(32'h03FF_FFFF, 32'(spt_pkg::RST_NOMINAL_FREQ)));
            if ($urandom_range(0, 1) == 0) run_grid_wave(100, 50.0);
            else run_noise(100);
        end
    endtask

    task automatic test_sample_noise();
        settle();
        write_defaults();
        run_noise(150);
    endtask

    initial begin : result_sink
        int gap;
        forever begin
            gap = pick_wait(RECEIVER);
            if (gap > 0) begin
                @(negedge i_clk) m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_pll_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: tracked_angle %0d",
                       $signed(m_axis_tdata[31:0]));
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want.tracked_angle) begin
                    $error("tracked_angle: expected %0d, got %0d", $signed(want.tracked_angle),
                           $signed(m_axis_tdata[31:0]));
                    fail_count++;
                end
                if (m_axis_tdata[56:32] !== want.freq_offset) begin
                    $error("freq_offset: expected %0d, got %0d", $signed(want.freq_offset),
                           $signed(m_axis_tdata[56:32]));
                    fail_count++;
                end
            end
        end
    end

    initial begin
        reset_tracker_model();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_sample_extremes();
        test_saturating_settings();
        test_zero_settings();
        test_grid_lock();
        test_off_nominal_grid();
        test_negative_frequency();
        test_random_settings();
        test_sample_noise();

        settle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
